[src/wsd_pkg.sv]
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants of the work-stealing deque
// Sizes, request and status codes, and the per-cell control bundle.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned CAPACITY    = 256;
  localparam int unsigned HANDLE_BITS = 32;

  // Steal readout: taps OR-ed in groups, one registered level, then a final OR
  localparam int unsigned GROUP_SIZE  = (CAPACITY >= 16) ? 16 : CAPACITY;
  localparam int unsigned NUM_GROUPS  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef logic [HANDLE_BITS-1:0] handle_t;

  typedef enum logic [1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_STEAL = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_STEAL = 1'b1
  } state_e;

  // Control broadcast to every cell of the chain
  typedef struct packed {
    logic push;       // shift toward the far end, cell 0 takes the new handle
    logic pop;        // shift toward cell 0, cell 0 leaves
    logic drop_last;  // the last occupied cell lets go of its handle
  } cell_ctrl_t;

endpackage

[src/wsd_cell.sv]
// ----------------------------------------------------------------------------
// wsd_cell: one slot of the deque chain
// Holds one handle and its occupancy bit; trades them with its neighbors.
// ----------------------------------------------------------------------------
module wsd_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wsd_pkg::cell_ctrl_t  ctrl_i,
  input  wsd_pkg::handle_t     left_data_i,
  input  logic                 left_valid_i,
  input  wsd_pkg::handle_t     right_data_i,
  input  logic                 right_valid_i,
  output wsd_pkg::handle_t     data_o,
  output logic                 valid_o,
  output wsd_pkg::handle_t     tap_o
);

  wsd_pkg::handle_t data_q;
  logic             valid_q, valid_d;
  logic             is_last;

  // Last occupied cell: held here, nothing held to the right
  assign is_last = valid_q & ~right_valid_i;

  always_comb begin
    valid_d = valid_q;
    if (ctrl_i.push) begin
      valid_d = left_valid_i;
    end else if (ctrl_i.pop) begin
      valid_d = right_valid_i;
    end else if (ctrl_i.drop_last && is_last) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      data_q <= left_data_i;
    end else if (ctrl_i.pop) begin
      data_q <= right_data_i;
    end
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;
  assign tap_o   = is_last ? data_q : '0;

endmodule

[src/wsd_reduce.sv]
// ----------------------------------------------------------------------------
// wsd_reduce: steal readout tree
// OR the one-hot cell taps in groups into registers, then OR the groups.
// ----------------------------------------------------------------------------
module wsd_reduce (
  input  logic              clk_i,
  input  wsd_pkg::handle_t  taps_i [wsd_pkg::CAPACITY],
  output wsd_pkg::handle_t  oldest_o
);

  wsd_pkg::handle_t grp_q [wsd_pkg::NUM_GROUPS];
  wsd_pkg::handle_t grp_d [wsd_pkg::NUM_GROUPS];

  always_comb begin
    for (int g = 0; g < int'(wsd_pkg::NUM_GROUPS); g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < int'(wsd_pkg::GROUP_SIZE); k++) begin
        if (g * int'(wsd_pkg::GROUP_SIZE) + k < int'(wsd_pkg::CAPACITY)) begin
          grp_d[g] = grp_d[g] | taps_i[g * int'(wsd_pkg::GROUP_SIZE) + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
  end

  always_comb begin
    oldest_o = '0;
    for (int g = 0; g < int'(wsd_pkg::NUM_GROUPS); g++) begin
      oldest_o = oldest_o | grp_q[g];
    end
  end

endmodule

[src/work_stealing_deque_top.sv]
// ----------------------------------------------------------------------------
// Results: push and pop load the output register the cycle after the transaction;
//   a steal first waits in S_STEAL on the registered OR tree over the cells.
//   Push and pop: one per cycle unless output stalls; none is taken during a steal.
// Reset: rst_ni clears all occupancy bits (deque empty), the request state and
//   the output valid flag; slot contents are not reset and are never read
//   before being written.
// ----------------------------------------------------------------------------
// work_stealing_deque_top: job-handle deque with LIFO pop and FIFO steal
// A chain of cells, cell 0 at the tail end. Occupied cells form a solid run
// starting at cell 0, so the newest handle sits in cell 0 and the oldest in
// the last occupied cell.
// ----------------------------------------------------------------------------
module work_stealing_deque_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] job_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] job_out_o
);

  localparam int unsigned Cap = wsd_pkg::CAPACITY;

  wsd_pkg::state_e     state_q, state_d;
  wsd_pkg::cell_ctrl_t ctrl;

  wsd_pkg::handle_t data_w  [Cap];
  wsd_pkg::handle_t taps_w  [Cap];
  logic             valid_w [Cap];
  wsd_pkg::handle_t oldest;

  logic             out_valid_q, out_valid_d;
  logic [1:0]       status_q, status_d;
  wsd_pkg::handle_t job_q, job_d;
  logic             out_load;
  logic             out_free;
  logic             in_fire;
  logic             empty, full;

  // Solid run from cell 0: cell 0 empty means deque empty, last cell full
  // means deque full.
  assign empty = ~valid_w[0];
  assign full  = valid_w[Cap-1];

  // Output register may take a new result when empty or being drained now
  assign out_free   = ~out_valid_q | out_ready_i;
  assign in_ready_o = (state_q == wsd_pkg::S_IDLE) && out_free;
  assign in_fire    = in_valid_i & in_ready_o;

  // --------------------------------------------------------------------------
  // Cell chain: left neighbor is toward the tail end (cell 0 takes the new
  // handle from the input), right neighbor toward the head end (the far end
  // sees an empty neighbor).
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < Cap; i++) begin : g_cell
    wsd_pkg::handle_t left_data, right_data;
    logic             left_valid, right_valid;

    if (i == 0) begin : g_first
      assign left_data  = wsd_pkg::handle_t'(job_in_i);
      assign left_valid = 1'b1;
    end else begin : g_mid_l
      assign left_data  = data_w[i-1];
      assign left_valid = valid_w[i-1];
    end

    if (i == Cap - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_mid_r
      assign right_data  = data_w[i+1];
      assign right_valid = valid_w[i+1];
    end

    wsd_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .left_data_i   (left_data),
      .left_valid_i  (left_valid),
      .right_data_i  (right_data),
      .right_valid_i (right_valid),
      .data_o        (data_w[i]),
      .valid_o       (valid_w[i]),
      .tap_o         (taps_w[i])
    );
  end

  // Oldest handle: only the last occupied cell drives its tap, so an OR of
  // all taps picks it. One register level inside, ready the cycle after.
  wsd_reduce u_reduce (
    .clk_i    (clk_i),
    .taps_i   (taps_w),
    .oldest_o (oldest)
  );

  // --------------------------------------------------------------------------
  // Request control
  // --------------------------------------------------------------------------
  always_comb begin
    state_d        = state_q;
    ctrl           = '0;
    out_load       = 1'b0;
    status_d       = status_q;
    job_d          = job_q;

    case (state_q)
      wsd_pkg::S_IDLE: begin
        if (in_fire) begin
          case (cmd_i)
            wsd_pkg::CMD_PUSH: begin
              out_load = 1'b1;
              job_d    = '0;
              if (full) begin
                status_d = wsd_pkg::ST_FULL;
              end else begin
                status_d  = wsd_pkg::ST_DONE;
                ctrl.push = 1'b1;
              end
            end
            wsd_pkg::CMD_POP: begin
              out_load = 1'b1;
              if (empty) begin
                status_d = wsd_pkg::ST_EMPTY;
                job_d    = '0;
              end else begin
                status_d = wsd_pkg::ST_DONE;
                job_d    = data_w[0];
                ctrl.pop = 1'b1;
              end
            end
            wsd_pkg::CMD_STEAL: begin
              if (empty) begin
                out_load = 1'b1;
                status_d = wsd_pkg::ST_EMPTY;
                job_d    = '0;
              end else begin
                // hold the chain while the tree gathers the oldest handle
                state_d = wsd_pkg::S_STEAL;
              end
            end
            default: begin
              // unused code: no state change, plain done with a zero handle
              out_load = 1'b1;
              status_d = wsd_pkg::ST_DONE;
              job_d    = '0;
            end
          endcase
        end
      end
      wsd_pkg::S_STEAL: begin
        if (out_free) begin
          out_load       = 1'b1;
          status_d       = wsd_pkg::ST_DONE;
          job_d          = oldest;
          ctrl.drop_last = 1'b1;
          state_d        = wsd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = wsd_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q & ~out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wsd_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload: advance only when a new result is loaded
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= status_d;
      job_q    <= job_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign job_out_o   = 32'(job_q);

endmodule
